>>> sv/satq_pkg.sv
// ----------------------------------------------------------------------------
// satq_pkg
// Shared types and constants of the sorted alarm timer queue.
// ----------------------------------------------------------------------------
package satq_pkg;

  // default number of alarm slots
  localparam int QUEUE_DEPTH_DEF = 16;

  // most expired alarms reported by one tick
  localparam int MAX_EXPIRE = 16;
  localparam int EXP_CNT_W  = $clog2(MAX_EXPIRE);

  // front to back item queue
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int TIME_W = 32;
  localparam int ID_W   = 16;

  // item class decided by the front
  typedef enum logic [1:0] {
    CLS_INSERT,
    CLS_BAD_ID,
    CLS_TICK
  } cls_t;

  // result kind codes
  typedef enum logic [1:0] {
    KIND_INSERTED = 2'd0,
    KIND_BAD_ID   = 2'd1,
    KIND_FULL     = 2'd2,
    KIND_EXPIRED  = 2'd3
  } kind_t;

  // back end sequencer states
  typedef enum logic {
    B_IDLE,
    B_EXPIRE
  } back_state_t;

  // classified item held between front and back
  typedef struct packed {
    cls_t            cls;
    logic [ID_W-1:0] alarm_id;
    logic [ID_W-1:0] group_id;
    logic [ID_W-1:0] delay;
  } item_t;

  // one alarm slot
  typedef struct packed {
    logic [TIME_W-1:0] expiry;
    logic [ID_W-1:0]   alarm_id;
    logic [ID_W-1:0]   group_id;
    logic [ID_W-1:0]   delay;
  } entry_t;

  // command from the sequencer to the slot row
  typedef struct packed {
    logic insert;
    logic pop;
  } cell_cmd_t;

  // status from the slot row to the sequencer
  typedef struct packed {
    logic full;
    logic empty;
    logic one_left;
    logic new_head;
  } cell_stat_t;

endpackage

>>> sv/sorted_alarm_timer_queue.sv
// ----------------------------------------------------------------------------
// sorted_alarm_timer_queue
// Bounded queue of alarms kept in expiry order, driven by insert and tick
// transactions.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready): in_op 0 inserts an alarm that expires
//   in_delay_seconds after the current time; in_op 1 advances time by one
//   second. a two-entry queue sits behind the input, so in_ready only drops
//   when both entries hold transactions the back end has not taken yet.
//   result channel (out_valid/out_ready): one result per insert (inserted,
//   bad id, or queue full, with out_last set) and one per expired alarm on a
//   tick, up to 16 per tick, out_last on the final one; a tick with nothing
//   due gives no result.
//   timing: an insert passes through the input queue and then the output
//   register; a tick passes the input queue, the expire state and then the
//   output register before its first expired alarm is valid.
//   throughput: inserts stream at one per cycle while the receiver takes
//   results; a tick advances the clock, then emits due alarms from the expire
//   state. the alarm slots are a row of compare cells, so inserts need no search.
//   when the receiver stalls the result stays in the output register, the
//   back end holds, and the input queue fills before in_ready drops.
//   reset empties the alarm slots, the input queue and the output register
//   and sets the time to zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_alarm_timer_queue #(
  parameter int QUEUE_DEPTH = satq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [15:0] in_alarm_id,
  input  logic [15:0] in_group_id,
  input  logic [15:0] in_delay_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [15:0] out_alarm_id,
  output logic [15:0] out_group_id,
  output logic [15:0] out_delay,
  output logic        out_new_earliest,
  output logic        out_last
);

  logic            item_valid;
  logic            item_pop;
  satq_pkg::item_t item;

  // accept and classify
  satq_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_alarm_id      (in_alarm_id),
    .in_group_id      (in_group_id),
    .in_delay_seconds (in_delay_seconds),
    .item_valid       (item_valid),
    .item             (item),
    .item_pop         (item_pop)
  );

  // carry out inserts and ticks
  satq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item_valid),
    .item             (item),
    .item_pop         (item_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_alarm_id     (out_alarm_id),
    .out_group_id     (out_group_id),
    .out_delay        (out_delay),
    .out_new_earliest (out_new_earliest),
    .out_last         (out_last)
  );

  // back end never takes from an empty queue
  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    item_pop |-> item_valid)
    else $error("item taken from empty queue");

  // insert outcomes are always the single result of their transaction
  a_insert_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != satq_pkg::KIND_EXPIRED) |-> out_last)
    else $error("insert result without last");

  // a bad id result really carries a zero id
  a_bad_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == satq_pkg::KIND_BAD_ID)
      |-> (out_alarm_id == '0 || out_group_id == '0))
    else $error("bad id result with nonzero ids");

  // expired alarms never raise the wake flag
  a_expired_no_wake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == satq_pkg::KIND_EXPIRED) |-> !out_new_earliest)
    else $error("expired result with new earliest set");

endmodule

>>> sv/satq_front.sv
// ----------------------------------------------------------------------------
// satq_front
// Accepts input transactions, classifies them and holds them in a short
// queue until the back end takes them.
// ----------------------------------------------------------------------------
module satq_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_op,
  input  logic [15:0]               in_alarm_id,
  input  logic [15:0]               in_group_id,
  input  logic [15:0]               in_delay_seconds,
  output logic                      item_valid,
  output satq_pkg::item_t           item,
  input  logic                      item_pop
);

  satq_pkg::item_t                       fifo_mem_r [satq_pkg::FIFO_DEPTH];
  logic [satq_pkg::FIFO_PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [satq_pkg::FIFO_PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [satq_pkg::FIFO_CNT_W-1:0]       cnt_r, cnt_nxt;
  satq_pkg::item_t                       cls_item;
  logic                                  push;

  // classify the incoming transaction
  always_comb begin
    cls_item.alarm_id = in_alarm_id;
    cls_item.group_id = in_group_id;
    cls_item.delay    = in_delay_seconds;
    if (in_op) begin
      cls_item.cls = satq_pkg::CLS_TICK;
    end else if (in_alarm_id == '0 || in_group_id == '0) begin
      cls_item.cls = satq_pkg::CLS_BAD_ID;
    end else begin
      cls_item.cls = satq_pkg::CLS_INSERT;
    end
  end

  // queue handshake
  assign in_ready   = (cnt_r != satq_pkg::FIFO_CNT_W'(satq_pkg::FIFO_DEPTH));
  assign push       = in_valid && in_ready;
  assign item_valid = (cnt_r != '0);
  assign item       = fifo_mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = item_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !item_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && item_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem_r[wr_ptr_r] <= cls_item;
    end
  end

endmodule

>>> sv/satq_cells.sv
// ----------------------------------------------------------------------------
// satq_cells
// Row of alarm slots kept in ascending expiry order. Every slot compares its
// own expiry with the new one, so an insert opens a gap and fills it; a pop
// shifts the whole row toward the head.
// ----------------------------------------------------------------------------
module satq_cells #(
  parameter int DEPTH = satq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  satq_pkg::cell_cmd_t   cmd,
  input  satq_pkg::entry_t      new_entry,
  output satq_pkg::entry_t      head,
  output logic [satq_pkg::TIME_W-1:0] second_expiry,
  output satq_pkg::cell_stat_t  stat
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  satq_pkg::entry_t   cell_r [DEPTH];
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [DEPTH-1:0]   occupied;
  logic [DEPTH-1:0]   lt;

  // per slot occupancy and ordering compare
  for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
    assign occupied[i] = (count_r > CNT_W'(i));
    assign lt[i]       = occupied[i] && (cell_r[i].expiry < new_entry.expiry);
  end

  // slot update: keep, take the new alarm, or shift
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (cmd.insert) begin
          if (!lt[i]) begin
            cell_r[i] <= new_entry;
          end
        end else if (cmd.pop) begin
          cell_r[i] <= cell_r[i+1];
        end
      end
    end else if (i == DEPTH - 1) begin : g_tail
      always_ff @(posedge clk) begin
        if (cmd.insert) begin
          if (!lt[i]) begin
            cell_r[i] <= lt[i-1] ? new_entry : cell_r[i-1];
          end
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (cmd.insert) begin
          if (!lt[i]) begin
            cell_r[i] <= lt[i-1] ? new_entry : cell_r[i-1];
          end
        end else if (cmd.pop) begin
          cell_r[i] <= cell_r[i+1];
        end
      end
    end
  end

  // fill count
  always_comb begin
    count_nxt = count_r;
    if (cmd.insert) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // status toward the sequencer
  assign head          = cell_r[0];
  assign second_expiry = cell_r[1].expiry;
  assign stat.full     = (count_r == CNT_W'(DEPTH));
  assign stat.empty    = (count_r == '0);
  assign stat.one_left = (count_r == CNT_W'(1));
  assign stat.new_head = !lt[0];

endmodule

>>> sv/satq_back.sv
// ----------------------------------------------------------------------------
// satq_back
// Takes classified items, keeps the clock of seconds, drives the slot row
// and loads the output register with each result.
// ----------------------------------------------------------------------------
module satq_back #(
  parameter int QUEUE_DEPTH = satq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_valid,
  input  satq_pkg::item_t       item,
  output logic                  item_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_kind,
  output logic [15:0]           out_alarm_id,
  output logic [15:0]           out_group_id,
  output logic [15:0]           out_delay,
  output logic                  out_new_earliest,
  output logic                  out_last
);

  satq_pkg::back_state_t               state_r, state_nxt;
  logic [satq_pkg::TIME_W-1:0]         time_r, time_nxt;
  logic [satq_pkg::EXP_CNT_W-1:0]      exp_cnt_r, exp_cnt_nxt;

  logic                                out_valid_r, out_valid_nxt;
  satq_pkg::kind_t                     out_kind_r, out_kind_nxt;
  logic [15:0]                         out_alarm_id_r, out_alarm_id_nxt;
  logic [15:0]                         out_group_id_r, out_group_id_nxt;
  logic [15:0]                         out_delay_r, out_delay_nxt;
  logic                                out_new_earliest_r, out_new_earliest_nxt;
  logic                                out_last_r, out_last_nxt;

  satq_pkg::cell_cmd_t                 cmd;
  satq_pkg::entry_t                    new_entry;
  satq_pkg::entry_t                    head;
  logic [satq_pkg::TIME_W-1:0]         second_expiry;
  satq_pkg::cell_stat_t                stat;

  logic                                slot_free;
  logic                                head_due;
  logic                                next_due;
  logic                                last_exp;
  logic                                emit;
  logic                                tick_start;
  logic                                exp_step;

  // alarm slot row
  satq_cells #(
    .DEPTH (QUEUE_DEPTH)
  ) u_cells (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .new_entry     (new_entry),
    .head          (head),
    .second_expiry (second_expiry),
    .stat          (stat)
  );

  // expiry of an insert and due tests against the clock
  assign new_entry.expiry   = time_r + {{(satq_pkg::TIME_W - 16){1'b0}}, item.delay};
  assign new_entry.alarm_id = item.alarm_id;
  assign new_entry.group_id = item.group_id;
  assign new_entry.delay    = item.delay;

  assign slot_free = !out_valid_r || out_ready;
  assign head_due  = !stat.empty && (head.expiry <= time_r);
  assign next_due  = !stat.one_left && (second_expiry <= time_r);
  assign last_exp  = (exp_cnt_r == satq_pkg::EXP_CNT_W'(satq_pkg::MAX_EXPIRE - 1))
                     || !next_due;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      satq_pkg::B_IDLE: begin
        if (item_valid && slot_free && item.cls == satq_pkg::CLS_TICK) begin
          state_nxt = satq_pkg::B_EXPIRE;
        end
      end
      satq_pkg::B_EXPIRE: begin
        if (!head_due || (slot_free && last_exp)) begin
          state_nxt = satq_pkg::B_IDLE;
        end
      end
      default: state_nxt = satq_pkg::B_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    item_pop             = 1'b0;
    cmd                  = '0;
    emit                 = 1'b0;
    tick_start           = 1'b0;
    exp_step             = 1'b0;
    out_kind_nxt         = satq_pkg::KIND_INSERTED;
    out_alarm_id_nxt     = item.alarm_id;
    out_group_id_nxt     = item.group_id;
    out_delay_nxt        = item.delay;
    out_new_earliest_nxt = 1'b0;
    out_last_nxt         = 1'b1;
    unique case (state_r)
      satq_pkg::B_IDLE: begin
        if (item_valid && slot_free) begin
          item_pop = 1'b1;
          unique case (item.cls)
            satq_pkg::CLS_TICK: begin
              tick_start = 1'b1;
            end
            satq_pkg::CLS_BAD_ID: begin
              emit         = 1'b1;
              out_kind_nxt = satq_pkg::KIND_BAD_ID;
            end
            satq_pkg::CLS_INSERT: begin
              emit = 1'b1;
              if (stat.full) begin
                out_kind_nxt = satq_pkg::KIND_FULL;
              end else begin
                out_kind_nxt         = satq_pkg::KIND_INSERTED;
                out_new_earliest_nxt = stat.new_head;
                cmd.insert           = 1'b1;
              end
            end
            default: begin
              tick_start = 1'b0;
            end
          endcase
        end
      end
      satq_pkg::B_EXPIRE: begin
        if (head_due && slot_free) begin
          emit             = 1'b1;
          exp_step         = 1'b1;
          cmd.pop          = 1'b1;
          out_kind_nxt     = satq_pkg::KIND_EXPIRED;
          out_alarm_id_nxt = head.alarm_id;
          out_group_id_nxt = head.group_id;
          out_delay_nxt    = head.delay;
          out_last_nxt     = last_exp;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // clock of seconds, expired count and output valid
  always_comb begin
    time_nxt      = tick_start ? time_r + 1'b1 : time_r;
    exp_cnt_nxt   = tick_start ? '0 : (exp_step ? exp_cnt_r + 1'b1 : exp_cnt_r);
    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= satq_pkg::B_IDLE;
      time_r      <= '0;
      exp_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      time_r      <= time_nxt;
      exp_cnt_r   <= exp_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r         <= out_kind_nxt;
      out_alarm_id_r     <= out_alarm_id_nxt;
      out_group_id_r     <= out_group_id_nxt;
      out_delay_r        <= out_delay_nxt;
      out_new_earliest_r <= out_new_earliest_nxt;
      out_last_r         <= out_last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_alarm_id     = out_alarm_id_r;
  assign out_group_id     = out_group_id_r;
  assign out_delay        = out_delay_r;
  assign out_new_earliest = out_new_earliest_r;
  assign out_last         = out_last_r;

endmodule
